FILE: src/lst_pkg.sv
package lst_pkg;

    // Sizes of the weight store, the feature buffer and the sigmoid table.
    localparam int MAX_FEATURES = 16;
    localparam int IDX_W = $clog2(MAX_FEATURES);
    localparam int CNT_W = $clog2(MAX_FEATURES + 1);
    localparam int SIG_SIZE = 256;
    localparam int SIG_IDX_W = $clog2(SIG_SIZE);

    // Stream payload widths (whole bytes) and configuration port widths.
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    // Fixed-point constants.
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] LR_MIN = 17'd7;
    localparam logic [15:0] SW_MIN = 16'd13;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEATURE_DIM   = 3'd0,
        REG_LEARNING_RATE = 3'd1,
        REG_L2_DECAY      = 3'd2,
        REG_TRAIN_ENABLE  = 3'd3,
        REG_BLEND_ALPHA   = 3'd4
    } cfg_reg_t;

    // Clamped configuration, as the datapath sees it.
    typedef struct packed {
        logic [CNT_W-1:0] dim;
        logic [16:0]      lr;
        logic [16:0]      l2;
        logic             train;
        logic [16:0]      alpha;
    } cfg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_SUM,
        ST_LOOK,
        ST_POST,
        ST_UPD_READ,
        ST_UPD_MUL,
        ST_UPD_SCALE,
        ST_UPD_WRITE,
        ST_BMUL,
        ST_BIAS,
        ST_DONE
    } state_t;

    typedef logic [16:0] sig_tab_t [SIG_SIZE];

    // Sigmoid of a nonnegative Q16 value, result Q0.16. Used at elaboration only.
    function automatic logic [16:0] sig_pos(input logic [63:0] a);
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] y3;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] n;
        logic [63:0] rem;
        logic [16:0] q;
        y = a << 6;
        y2 = (y * y) >> 30;
        y3 = (y2 * y) >> 30;
        e = (64'd1 << 30) - y + (y2 >> 1) - (y3 / 64'd6);
        for (int k = 0; k < 8; k++)
        begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        d = (64'd1 << 30) + e;
        n = (64'd1 << 46) + (d >> 1);
        rem = 64'd0;
        q = 17'd0;
        // Restoring long division of n by d.
        for (int b = 47; b >= 0; b--)
        begin
            rem = {rem[62:0], n[b]};
            q = {q[15:0], 1'b0};
            if (rem >= d)
            begin
                rem = rem - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sig_tab_t build_sig_table();
        sig_tab_t tab;
        logic signed [63:0] xq;
        for (int i = 0; i < SIG_SIZE; i++)
        begin
            xq = $signed((64'(i) << 20) / SIG_SIZE) - 64'sd524288;
            if (xq >= 0)
            begin
                tab[i] = sig_pos(xq);
            end
            else
            begin
                tab[i] = ONE_Q16 - sig_pos(-xq);
            end
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TABLE = build_sig_table();

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: src/lst_ram.sv
module lst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/lst_cfg.sv
module lst_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lst_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lst_pkg::cfg_t                   cfg
);

    lst_pkg::cfg_t cfg_reg;
    lst_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    // Each register is clamped to its legal range as it is written.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lst_pkg::REG_FEATURE_DIM:
                begin
                    if (cfg_data[4:0] == 5'd0)
                    begin
                        cfg_next.dim = lst_pkg::CNT_W'(1);
                    end
                    else if (32'(cfg_data[4:0]) > lst_pkg::MAX_FEATURES)
                    begin
                        cfg_next.dim = lst_pkg::CNT_W'(lst_pkg::MAX_FEATURES);
                    end
                    else
                    begin
                        cfg_next.dim = lst_pkg::CNT_W'(cfg_data[4:0]);
                    end
                end
                lst_pkg::REG_LEARNING_RATE:
                begin
                    if (cfg_data < lst_pkg::LR_MIN)
                    begin
                        cfg_next.lr = lst_pkg::LR_MIN;
                    end
                    else if (cfg_data > lst_pkg::ONE_Q16)
                    begin
                        cfg_next.lr = lst_pkg::ONE_Q16;
                    end
                    else
                    begin
                        cfg_next.lr = cfg_data;
                    end
                end
                lst_pkg::REG_L2_DECAY:
                begin
                    cfg_next.l2 = (cfg_data > lst_pkg::ONE_Q16) ? lst_pkg::ONE_Q16 : cfg_data;
                end
                lst_pkg::REG_TRAIN_ENABLE:
                begin
                    cfg_next.train = cfg_data[0];
                end
                lst_pkg::REG_BLEND_ALPHA:
                begin
                    cfg_next.alpha = (cfg_data > lst_pkg::ONE_Q16) ?
                                     lst_pkg::ONE_Q16 : cfg_data;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim <= lst_pkg::CNT_W'(13);
            cfg_reg.lr <= 17'd655;
            cfg_reg.l2 <= 17'd0;
            cfg_reg.train <= 1'b1;
            cfg_reg.alpha <= lst_pkg::ONE_Q16;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/logistic_sgd_trainer_unit.sv
// Each feature element passes through a weight memory read, then a multiply-accumulate.
// A last element adds the scoring steps (sum, sigmoid lookup, post-processing); with training
// on and label bit 1 clear, an update pass reads, multiplies, scales and writes back each in-use
// weight, then updates the bias. A new element is accepted only in the idle state, so the next
// example waits until this one is done; the result waits while the output register is full.
// Reset clears bias, count, accumulator and the buffer and weight valid bits, and loads defaults.
module logistic_sgd_trainer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] feature_value, [17:16] label_class, [33:18] sample_weight, zero pad.
    input  logic [lst_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [16:0] probability, [37:17] boost_value, [38] updated, zero pad.
    output logic [lst_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lst_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW = lst_pkg::IDX_W;
    localparam int CW = lst_pkg::CNT_W;
    localparam int MF = lst_pkg::MAX_FEATURES;

    lst_pkg::cfg_t cfg;

    lst_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Memory ports.
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [IW-1:0] w_raddr;
    logic [31:0]   w_rdata;
    logic          f_we;
    logic [IW-1:0] f_waddr;
    logic [15:0]   f_wdata;
    logic [IW-1:0] f_raddr;
    logic [15:0]   f_rdata;

    lst_ram #(.WIDTH(32), .DEPTH(MF)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    lst_ram #(.WIDTH(16), .DEPTH(MF)) u_feature_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // Registers.
    lst_pkg::state_t          state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [63:0]       acc_reg, acc_next;
    logic signed [31:0]       bias_reg, bias_next;
    logic signed [15:0]       f_reg, f_next;
    logic                     acc_en_reg, acc_en_next;
    logic                     last_reg, last_next;
    logic [1:0]               label_reg, label_next;
    logic [15:0]              sw_reg, sw_next;
    logic signed [63:0]       x_reg, x_next;
    logic [16:0]              p_reg, p_next;
    logic signed [20:0]       boost_reg, boost_next;
    logic signed [34:0]       errsw_reg, errsw_next;
    logic                     train_reg, train_next;
    logic [CW-1:0]            upd_idx_reg, upd_idx_next;
    logic signed [31:0]       w_hold_reg, w_hold_next;
    logic signed [50:0]       pa_reg, pa_next;
    logic signed [49:0]       pb_reg, pb_next;
    logic signed [57:0]       prod_reg, prod_next;
    logic signed [52:0]       bprod_reg, bprod_next;
    logic [MF-1:0]            fvalid_reg, fvalid_next;
    logic [MF-1:0]            wvalid_reg, wvalid_next;
    logic                     wok_reg, wok_next;
    logic                     fok_reg, fok_next;
    logic                     out_valid_reg, out_valid_next;
    logic [lst_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Combinational datapath terms.
    logic signed [31:0] w_eff;
    logic signed [15:0] f_eff;
    logic signed [47:0] mac_prod;
    logic signed [63:0] xs;
    logic [lst_pkg::SIG_IDX_W-1:0] sig_idx;
    logic signed [17:0] p_diff;
    logic signed [35:0] blend_prod;
    logic signed [40:0] boost_full;
    logic signed [17:0] err;
    logic [15:0]        sw_floor;
    logic signed [55:0] grad;
    logic signed [55:0] grad_rnd;
    logic signed [39:0] g20;
    logic signed [57:0] prod_rnd;
    logic signed [37:0] delta;
    logic signed [52:0] bprod_rnd;
    logic signed [28:0] db;
    logic               s_fire;
    logic               in_range;

    // Weight entries never written since reset, and feature entries not written in this example, read as zero.
    assign w_eff = wok_reg ? $signed(w_rdata) : 32'sd0;
    assign f_eff = fok_reg ? $signed(f_rdata) : 16'sd0;

    assign mac_prod = w_eff * f_reg;

    // Sigmoid index from the Q.28 sum, saturated at both ends of the table.
    assign xs = x_reg + 64'sd2147483648;
    always_comb
    begin
        if (xs[63])
        begin
            sig_idx = '0;
        end
        else if (|xs[62:32])
        begin
            sig_idx = '1;
        end
        else
        begin
            sig_idx = xs[31 -: lst_pkg::SIG_IDX_W];
        end
    end

    // Boost: 24 * alpha * (p - 0.5), rounded from Q.32 to Q.16.
    assign p_diff = $signed({1'b0, p_reg}) - 18'sd32768;
    assign blend_prod = p_diff * $signed({1'b0, cfg.alpha});
    assign boost_full = (41'(blend_prod) <<< 4) + (41'(blend_prod) <<< 3) + 41'sd32768;

    // Error times floored sample weight.
    assign err = $signed({1'b0, p_reg}) - ((label_reg == 2'b01) ? 18'sd65536 : 18'sd0);
    assign sw_floor = (sw_reg < lst_pkg::SW_MIN) ? lst_pkg::SW_MIN : sw_reg;

    // Weight step terms.
    assign grad = 56'(pa_reg) + (56'(pb_reg) <<< 4);
    assign grad_rnd = grad + 56'sd32768;
    assign g20 = 40'(grad_rnd >>> 16);
    assign prod_rnd = prod_reg + 58'sd524288;
    assign delta = 38'(prod_rnd >>> 20);
    assign bprod_rnd = bprod_reg + 53'sd8388608;
    assign db = 29'(bprod_rnd >>> 24);

    assign s_tready = (state_reg == lst_pkg::ST_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign in_range = (count_reg < cfg.dim);

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        acc_next = acc_reg;
        bias_next = bias_reg;
        f_next = f_reg;
        acc_en_next = acc_en_reg;
        last_next = last_reg;
        label_next = label_reg;
        sw_next = sw_reg;
        x_next = x_reg;
        p_next = p_reg;
        boost_next = boost_reg;
        errsw_next = errsw_reg;
        train_next = train_reg;
        upd_idx_next = upd_idx_reg;
        w_hold_next = w_hold_reg;
        pa_next = pa_reg;
        pb_next = pb_reg;
        prod_next = prod_reg;
        bprod_next = bprod_reg;
        fvalid_next = fvalid_reg;
        wvalid_next = wvalid_reg;
        wok_next = wok_reg;
        fok_next = fok_reg;
        out_data_next = out_data_reg;
        out_valid_next = (out_valid_reg && !m_tready);

        w_we = 1'b0;
        w_waddr = upd_idx_reg[IW-1:0];
        w_wdata = 32'(lst_pkg::sat32(64'(w_hold_reg) - 64'(delta)));
        w_raddr = upd_idx_reg[IW-1:0];
        f_we = 1'b0;
        f_waddr = count_reg[IW-1:0];
        f_wdata = s_tdata[15:0];
        f_raddr = upd_idx_reg[IW-1:0];

        case (state_reg)
            lst_pkg::ST_IDLE:
            begin
                w_raddr = count_reg[IW-1:0];
                if (s_fire)
                begin
                    f_next = $signed(s_tdata[15:0]);
                    label_next = s_tdata[17:16];
                    sw_next = s_tdata[33:18];
                    last_next = s_tlast;
                    acc_en_next = in_range;
                    wok_next = wvalid_reg[count_reg[IW-1:0]];
                    if (in_range)
                    begin
                        f_we = 1'b1;
                        fvalid_next[count_reg[IW-1:0]] = 1'b1;
                    end
                    if (32'(count_reg) < MF)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    state_next = lst_pkg::ST_ACC;
                end
            end
            lst_pkg::ST_ACC:
            begin
                if (acc_en_reg)
                begin
                    acc_next = acc_reg + 64'(mac_prod);
                end
                state_next = last_reg ? lst_pkg::ST_SUM : lst_pkg::ST_IDLE;
            end
            lst_pkg::ST_SUM:
            begin
                x_next = acc_reg + (64'(bias_reg) <<< 12);
                state_next = lst_pkg::ST_LOOK;
            end
            lst_pkg::ST_LOOK:
            begin
                p_next = lst_pkg::SIG_TABLE[sig_idx];
                state_next = lst_pkg::ST_POST;
            end
            lst_pkg::ST_POST:
            begin
                boost_next = boost_full[36:16];
                errsw_next = err * $signed({1'b0, sw_floor});
                train_next = cfg.train && !label_reg[1];
                upd_idx_next = '0;
                state_next = (cfg.train && !label_reg[1]) ?
                             lst_pkg::ST_UPD_READ : lst_pkg::ST_DONE;
            end
            lst_pkg::ST_UPD_READ:
            begin
                wok_next = wvalid_reg[upd_idx_reg[IW-1:0]];
                fok_next = fvalid_reg[upd_idx_reg[IW-1:0]];
                state_next = lst_pkg::ST_UPD_MUL;
            end
            lst_pkg::ST_UPD_MUL:
            begin
                pa_next = errsw_reg * f_eff;
                pb_next = $signed({1'b0, cfg.l2}) * w_eff;
                w_hold_next = w_eff;
                state_next = lst_pkg::ST_UPD_SCALE;
            end
            lst_pkg::ST_UPD_SCALE:
            begin
                prod_next = g20 * $signed({1'b0, cfg.lr});
                state_next = lst_pkg::ST_UPD_WRITE;
            end
            lst_pkg::ST_UPD_WRITE:
            begin
                w_we = 1'b1;
                wvalid_next[upd_idx_reg[IW-1:0]] = 1'b1;
                upd_idx_next = upd_idx_reg + CW'(1);
                state_next = ((upd_idx_reg + CW'(1)) == cfg.dim) ?
                             lst_pkg::ST_BMUL : lst_pkg::ST_UPD_READ;
            end
            lst_pkg::ST_BMUL:
            begin
                bprod_next = errsw_reg * $signed({1'b0, cfg.lr});
                state_next = lst_pkg::ST_BIAS;
            end
            lst_pkg::ST_BIAS:
            begin
                bias_next = lst_pkg::sat32(64'(bias_reg) - 64'(db));
                state_next = lst_pkg::ST_DONE;
            end
            lst_pkg::ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {1'b0, train_reg, boost_reg, p_reg};
                    acc_next = '0;
                    count_next = '0;
                    fvalid_next = '0;
                    state_next = lst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lst_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lst_pkg::ST_IDLE;
            count_reg <= '0;
            acc_reg <= '0;
            bias_reg <= '0;
            fvalid_reg <= '0;
            wvalid_reg <= '0;
            out_valid_reg <= 1'b0;
            train_reg <= 1'b0;
            upd_idx_reg <= '0;
            acc_en_reg <= 1'b0;
            last_reg <= 1'b0;
            wok_reg <= 1'b0;
            fok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            acc_reg <= acc_next;
            bias_reg <= bias_next;
            fvalid_reg <= fvalid_next;
            wvalid_reg <= wvalid_next;
            out_valid_reg <= out_valid_next;
            train_reg <= train_next;
            upd_idx_reg <= upd_idx_next;
            acc_en_reg <= acc_en_next;
            last_reg <= last_next;
            wok_reg <= wok_next;
            fok_reg <= fok_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        label_reg <= label_next;
        sw_reg <= sw_next;
        x_reg <= x_next;
        p_reg <= p_next;
        boost_reg <= boost_next;
        errsw_reg <= errsw_next;
        w_hold_reg <= w_hold_next;
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        prod_reg <= prod_next;
        bprod_reg <= bprod_next;
        out_data_reg <= out_data_next;
    end

endmodule
